/* design/assert_macros.svh */
// shared assertion macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error(msg);

// consequent holds in the same cycle as the antecedent
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

`endif

/* design/cdc_pkg.sv */
`timescale 1ns / 1ps

package cdc_pkg;

   localparam int DAY_W    = 5;
   localparam int MONTH_W  = 4;
   localparam int YEAR_W   = 14;
   localparam int WDAY_W   = 3;
   localparam int ACTION_W = 2;
   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 32;

   typedef enum logic [ACTION_W-1:0] {
      ACT_LOAD = 2'd0,
      ACT_NEXT = 2'd1,
      ACT_PREV = 2'd2,
      ACT_CMP  = 2'd3
   } action_type;

   // year in the top bits so a packed compare orders dates
   typedef struct packed {
      logic [YEAR_W-1:0]  year;
      logic [MONTH_W-1:0] month;
      logic [DAY_W-1:0]   day;
   } date_type;

   typedef struct packed {
      logic before_res;
      logic same;
      logic after;
      logic error;
   } flags_type;

   localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
   localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
   localparam logic [MONTH_W-1:0] MONTH_MAR = 4'd3;
   localparam logic [MONTH_W-1:0] MONTH_APR = 4'd4;
   localparam logic [MONTH_W-1:0] MONTH_JUN = 4'd6;
   localparam logic [MONTH_W-1:0] MONTH_SEP = 4'd9;
   localparam logic [MONTH_W-1:0] MONTH_NOV = 4'd11;
   localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

   localparam logic [DAY_W-1:0] DAY_FIRST     = 5'd1;
   localparam logic [DAY_W-1:0] DAYS_LONG     = 5'd31;
   localparam logic [DAY_W-1:0] DAYS_SHORT    = 5'd30;
   localparam logic [DAY_W-1:0] DAYS_FEB      = 5'd28;
   localparam logic [DAY_W-1:0] DAYS_FEB_LEAP = 5'd29;

   localparam logic [YEAR_W-1:0] YEAR_FIRST = 14'd1;

   // floor(y / 25) = (y * 5243) >> 17, exact for 14-bit y
   localparam logic [12:0] RECIP_25 = 13'd5243;

   function automatic logic [9:0] div25(input logic [YEAR_W-1:0] y);
      logic [26:0] prod;
      prod = 27'(y) * 27'(RECIP_25);
      return prod[26:17];
   endfunction

   function automatic logic mult25(input logic [YEAR_W-1:0] y);
      logic [9:0]        q;
      logic [YEAR_W-1:0] back;
      q    = div25(y);
      back = 14'({q, 4'b0000}) + 14'({q, 3'b000}) + 14'(q);
      return back == y;
   endfunction

   // div by 100 needs div by 4 and 25, div by 400 needs div by 16 and 25
   function automatic logic leap_year(input logic [YEAR_W-1:0] y);
      return (y[1:0] == 2'b00) && (!mult25(y) || (y[3:2] == 2'b00));
   endfunction

   function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                  input logic leap);
      logic [DAY_W-1:0] len;
      if (m == MONTH_FEB) begin
         len = leap ? DAYS_FEB_LEAP : DAYS_FEB;
      end else if (m inside {MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV}) begin
         len = DAYS_SHORT;
      end else begin
         len = DAYS_LONG;
      end
      return len;
   endfunction

   function automatic logic [WDAY_W-1:0] month_offset(input logic [MONTH_W-1:0] m);
      logic [WDAY_W-1:0] off;
      case (m)
         4'd1:    off = 3'd0;
         4'd2:    off = 3'd3;
         4'd3:    off = 3'd2;
         4'd4:    off = 3'd5;
         4'd5:    off = 3'd0;
         4'd6:    off = 3'd3;
         4'd7:    off = 3'd5;
         4'd8:    off = 3'd1;
         4'd9:    off = 3'd4;
         4'd10:   off = 3'd6;
         4'd11:   off = 3'd2;
         4'd12:   off = 3'd4;
         default: off = 3'd0;
      endcase
      return off;
   endfunction

   // 8 is 1 mod 7, so octal digits are summed and folded
   function automatic logic [WDAY_W-1:0] mod7(input logic [14:0] s);
      logic [5:0] a;
      logic [3:0] b;
      a = 6'(s[2:0]) + 6'(s[5:3]) + 6'(s[8:6]) + 6'(s[11:9]) + 6'(s[14:12]);
      b = 4'(a[2:0]) + 4'(a[5:3]);
      return (b >= 4'd7) ? 3'(b - 4'd7) : b[2:0];
   endfunction

endpackage

/* design/calendar_date_counter.sv */
`timescale 1ns / 1ps

// Gregorian date counter: each request loads a date, steps one day forward or
// back, or only compares, and returns one response with the stored date, its
// weekday (0 is Sunday) and before/same/after flags against the request date.
// A request is taken every cycle while no held response stalls the stages. A
// request passes four registers: the input register, the date update stage and
// two weekday stages (year quotients, then sum and mod 7), in that order,
// before rsp_tvalid rises; a held response stalls the stages behind it. Bad
// loads and steps past 0001-01-01 or YEAR_MAX-12-31 keep the date and set
// error. Reset date is 0001-01-01.

module calendar_date_counter import cdc_pkg::*; #(
   parameter int YEAR_MAX = 9999
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // in_day, in_month, in_year
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // action
   input  logic [ACTION_W-1:0]   req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // cur_day, cur_month, cur_year, weekday, before_res, same, after, error
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   logic      step_valid;
   logic      step_ready;
   date_type  step_date;
   flags_type step_flags;

   cdc_step #(
      .YEAR_MAX (YEAR_MAX)
   ) u_step (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .out_valid  (step_valid),
      .out_ready  (step_ready),
      .out_date   (step_date),
      .out_flags  (step_flags)
   );

   cdc_wday u_wday (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (step_valid),
      .in_ready   (step_ready),
      .in_date    (step_date),
      .in_flags   (step_flags),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

/* design/cdc_step.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cdc_step import cdc_pkg::*; #(
   parameter int YEAR_MAX = 9999
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic [ACTION_W-1:0]   req_tuser,
   output logic                  out_valid,
   input  logic                  out_ready,
   output date_type              out_date,
   output flags_type             out_flags
);

   logic       v1_ff;
   action_type act_ff;
   date_type   in_ff;
   logic       load_ok_ff;

   logic       v2_ff;
   date_type   date_ff;
   flags_type  flags_ff;

   date_type   req_date;
   logic       load_ok_in;
   logic       r2;
   date_type   date_in;
   flags_type  flags_in;

   assign req_date.day   = req_tdata[4:0];
   assign req_date.month = req_tdata[8:5];
   assign req_date.year  = req_tdata[22:9];

   assign r2         = !v2_ff || out_ready;
   assign req_tready = !v1_ff || r2;

   // load check at the input register
   always_comb begin
      load_ok_in = (req_date.month >= MONTH_JAN) && (req_date.month <= MONTH_DEC) &&
                   (req_date.year >= YEAR_FIRST) &&
                   (req_date.year <= YEAR_W'(YEAR_MAX)) &&
                   (req_date.day >= DAY_FIRST) &&
                   (req_date.day <= month_len(req_date.month, leap_year(req_date.year)));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (req_tready) begin
         v1_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         act_ff     <= action_type'(req_tuser);
         in_ff      <= req_date;
         load_ok_ff <= load_ok_in;
      end
   end

   // date update and compare
   always_comb begin
      logic             leap;
      logic [DAY_W-1:0] cur_len;
      logic [DAY_W-1:0] prev_len;
      date_type         d;
      logic             err;
      leap     = leap_year(date_ff.year);
      cur_len  = month_len(date_ff.month, leap);
      prev_len = month_len(date_ff.month - MONTH_JAN, leap);
      d        = date_ff;
      err      = 1'b0;
      case (act_ff)
         ACT_LOAD: begin
            if (load_ok_ff) begin
               d = in_ff;
            end else begin
               err = 1'b1;
            end
         end
         ACT_NEXT: begin
            if ((date_ff.year >= YEAR_W'(YEAR_MAX)) && (date_ff.month == MONTH_DEC) &&
                (date_ff.day == DAYS_LONG)) begin
               err = 1'b1;
            end else if (date_ff.day < cur_len) begin
               d.day = date_ff.day + DAY_FIRST;
            end else begin
               d.day = DAY_FIRST;
               if (date_ff.month < MONTH_DEC) begin
                  d.month = date_ff.month + MONTH_JAN;
               end else begin
                  d.month = MONTH_JAN;
                  d.year  = date_ff.year + YEAR_FIRST;
               end
            end
         end
         ACT_PREV: begin
            if ((date_ff.year <= YEAR_FIRST) && (date_ff.month == MONTH_JAN) &&
                (date_ff.day == DAY_FIRST)) begin
               err = 1'b1;
            end else if (date_ff.day > DAY_FIRST) begin
               d.day = date_ff.day - DAY_FIRST;
            end else if (date_ff.month > MONTH_JAN) begin
               d.month = date_ff.month - MONTH_JAN;
               d.day   = prev_len;
            end else begin
               d.month = MONTH_DEC;
               d.year  = date_ff.year - YEAR_FIRST;
               d.day   = DAYS_LONG;
            end
         end
         default: begin
            d = date_ff;
         end
      endcase
      date_in             = d;
      flags_in.before_res = d < in_ff;
      flags_in.same       = d == in_ff;
      flags_in.after      = !(d < in_ff) && !(d == in_ff);
      flags_in.error      = err;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff         <= 1'b0;
         date_ff.day   <= DAY_FIRST;
         date_ff.month <= MONTH_JAN;
         date_ff.year  <= YEAR_FIRST;
      end else if (r2) begin
         v2_ff <= v1_ff;
         if (v1_ff) begin
            date_ff <= date_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (r2 && v1_ff) begin
         flags_ff <= flags_in;
      end
   end

   assign out_valid = v2_ff;
   assign out_date  = date_ff;
   assign out_flags = flags_ff;

   `ASSERT_ALWAYS(a_date_legal, clock, reset,
      (date_ff.month >= MONTH_JAN) && (date_ff.month <= MONTH_DEC) &&
      (date_ff.day >= DAY_FIRST) && (date_ff.year >= YEAR_FIRST),
      "stored date left the legal range")
   `ASSERT_IMPLY(a_err_keeps_date, clock, reset, v2_ff && flags_ff.error,
      $stable(date_ff), "rejected request changed the stored date")
   `ASSERT_IMPLY(a_one_order, clock, reset, v2_ff,
      $onehot({flags_ff.before_res, flags_ff.same, flags_ff.after}),
      "compare flags not exclusive")

endmodule

/* design/cdc_wday.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cdc_wday import cdc_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  date_type              in_date,
   input  flags_type             in_flags,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   logic              v3_ff;
   date_type          date3_ff;
   flags_type         flags3_ff;
   logic [YEAR_W-1:0] yy3_ff;
   logic [9:0]        q100_ff;
   logic [9:0]        q400_ff;

   logic              v4_ff;
   date_type          date4_ff;
   flags_type         flags4_ff;
   logic [WDAY_W-1:0] wday4_ff;

   logic              r3;
   logic              r4;
   logic [YEAR_W-1:0] yy_in;
   logic [9:0]        q100_in;
   logic [9:0]        q400_in;
   logic [14:0]       sum_in;
   logic [WDAY_W-1:0] wday_in;

   assign r4       = !v4_ff || rsp_tready;
   assign r3       = !v3_ff || r4;
   assign in_ready = r3;

   // january and february count with the year before
   always_comb begin
      yy_in   = (in_date.month < MONTH_MAR) ? in_date.year - YEAR_FIRST : in_date.year;
      q100_in = div25(YEAR_W'(yy_in[YEAR_W-1:2]));
      q400_in = div25(YEAR_W'(yy_in[YEAR_W-1:4]));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (r3) begin
         v3_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (r3 && in_valid) begin
         date3_ff  <= in_date;
         flags3_ff <= in_flags;
         yy3_ff    <= yy_in;
         q100_ff   <= q100_in;
         q400_ff   <= q400_in;
      end
   end

   always_comb begin
      sum_in = 15'(yy3_ff) + 15'(yy3_ff[YEAR_W-1:2]) - 15'(q100_ff) + 15'(q400_ff) +
               15'(month_offset(date3_ff.month)) + 15'(date3_ff.day);
      wday_in = mod7(sum_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else if (r4) begin
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (r4 && v3_ff) begin
         date4_ff  <= date3_ff;
         flags4_ff <= flags3_ff;
         wday4_ff  <= wday_in;
      end
   end

   assign rsp_tvalid = v4_ff;
   assign rsp_tdata  = {2'b00, flags4_ff.error, flags4_ff.after, flags4_ff.same,
                        flags4_ff.before_res, wday4_ff, date4_ff.year,
                        date4_ff.month, date4_ff.day};

   `ASSERT_IMPLY(a_wday_range, clock, reset, v4_ff, wday4_ff <= 3'd6,
      "weekday out of range")

endmodule
